// ===== sv/acd_pkg.sv =====
// Shared types and constants for the affinity chunk task dispatcher.
// No dependencies.
package acd_pkg;

    localparam int unsigned NodeW = 5;
    localparam int unsigned ReqW  = 4;
    localparam int unsigned DataW = 32;
    localparam logic [6:0]  SplitThreshold = 7'd100;

    localparam logic CfgNodeCount = 1'b0;
    localparam logic CfgTotalSize = 1'b1;

    // request passed from the front part to the back part
    typedef struct packed {
        logic [ReqW-1:0] requester;
    } acd_req_t;

    // result leaving the back part
    typedef struct packed {
        logic             granted;
        logic [DataW-1:0] task_start;
        logic [DataW-1:0] task_end;
    } acd_res_t;

endpackage

// ===== sv/acd_front.sv =====
// Front part: accepts requests and holds them in a short queue.
// Depends on acd_pkg.
module acd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  acd_pkg::acd_req_t in_req,
    output logic              q_valid,
    input  logic              q_ready,
    output acd_pkg::acd_req_t q_req
);
    import acd_pkg::*;

    acd_req_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_req;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rp_reg != $past(rp_reg)) else $error("read pointer stuck");
`endif

endmodule

// ===== sv/acd_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on acd_pkg.
module acd_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [acd_pkg::DataW-1:0] dividend,
    input  logic [acd_pkg::NodeW:0]   divisor,
    output logic                     done,
    output logic [acd_pkg::DataW-1:0] quotient
);
    import acd_pkg::*;

    localparam int unsigned CntW = $clog2(DataW + 1);

    logic [DataW-1:0] q_reg, q_next;
    logic [NodeW:0]   r_reg, r_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [NodeW:0]   d_reg, d_next;
    logic             busy_reg, busy_next;
    logic [NodeW+1:0] trial;

    assign quotient = q_reg;
    assign done     = busy_reg && (cnt_reg == CntW'(0));
    assign trial    = {r_reg, q_reg[DataW-1]};

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; cnt_next = cnt_reg;
        d_next = d_reg; busy_next = busy_reg;
        if (start)
        begin
            q_next = dividend; r_next = '0; d_next = divisor;
            cnt_next = CntW'(DataW); busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != CntW'(0))
        begin
            cnt_next = cnt_reg - CntW'(1);
            if (trial >= {1'b0, d_reg})
            begin
                r_next = (NodeW+1)'(trial - {1'b0, d_reg});
                q_next = {q_reg[DataW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[NodeW:0];
                q_next = {q_reg[DataW-2:0], 1'b0};
            end
        end
        else if (done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

`ifndef SYNTH
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == CntW'(DataW)) else $error("divider not loaded");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && d_reg != '0 |-> r_reg < d_reg) else $error("remainder too large");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !done) else $error("done held");
`endif

endmodule

// ===== sv/acd_back.sv =====
// Back part: builds bundles and slots, grants ranges, holds the result register.
// Depends on acd_pkg and acd_divider.
module acd_back #(
    parameter int unsigned MAX_NODES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [acd_pkg::DataW-1:0] cfg_data,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  acd_pkg::acd_req_t         q_req,
    output logic                      res_valid,
    input  logic                      res_ready,
    output acd_pkg::acd_res_t         res
);
    import acd_pkg::*;

    localparam int unsigned SlotW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV1  = 7'b0000100,
        S_DIV2  = 7'b0001000,
        S_FILL  = 7'b0010000,
        S_PICK  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [NodeW-1:0]     ncfg_reg;
    logic [DataW-1:0]     total_reg;
    logic [DataW-1:0]     rem_reg, rem_next;
    logic [DataW-1:0]     nbs_reg, nbs_next;
    logic                 fin_reg, fin_next;
    logic [MAX_NODES-1:0] full_reg, full_next;
    logic [1:0]           tries_reg, tries_next;
    logic [DataW-1:0]     len_reg, len_next;
    logic [DataW-1:0]     bend_reg, bend_next;
    logic [DataW-1:0]     ts_reg, ts_next;
    logic [DataW-1:0]     pos_reg, pos_next;
    logic [SlotW-1:0]     fi_reg, fi_next;
    logic [ReqW-1:0]      req_reg, req_next;
    logic [SlotW-1:0]     k_reg, k_next;
    logic                 any_reg, any_next;
    logic                 rv_reg, rv_next;
    acd_res_t             res_reg, res_next;
    logic [DataW-1:0]     sstart_mem [MAX_NODES];
    logic [DataW-1:0]     send_mem [MAX_NODES];
    logic                 wr_en;
    logic [DataW-1:0]     wr_s, wr_e;
    logic [DataW-1:0]     rd_s, rd_e;

    logic [6:0]           n_eff;
    logic [DataW+6:0]     thresh;
    logic                 div_start, div_done;
    logic [DataW-1:0]     div_a, div_q;
    logic [NodeW:0]       div_b;
    logic [DataW:0]       pe_sum;
    logic [DataW-1:0]     pe;
    logic [6:0]           fi_ext;
    logic                 req_ok;
    logic [SlotW-1:0]     lowest;
    logic                 found;

    always_comb
    begin
        if (ncfg_reg == '0)
            n_eff = 7'd1;
        else if (7'(ncfg_reg) > 7'(MAX_NODES))
            n_eff = 7'(MAX_NODES);
        else
            n_eff = 7'(ncfg_reg);
    end

    assign thresh = (DataW+7)'(SplitThreshold) * (DataW+7)'(n_eff);
    assign pe_sum = {1'b0, pos_reg} + {1'b0, ts_reg};
    assign pe     = (pe_sum > {1'b0, bend_reg}) ? bend_reg : pe_sum[DataW-1:0];
    assign fi_ext = 7'(fi_reg);
    assign req_ok = (7'(req_reg) < n_eff) && (7'(req_reg) < 7'(MAX_NODES))
                    && full_reg[SlotW'(req_reg)];

    always_comb
    begin
        lowest = '0;
        found  = 1'b0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (full_reg[i] && (7'(i) < n_eff))
            begin
                lowest = SlotW'(i);
                found  = 1'b1;
            end
        end
    end

    acd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_ready   = (state_reg == S_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        rem_next = rem_reg; nbs_next = nbs_reg; fin_next = fin_reg;
        full_next = full_reg; tries_next = tries_reg; len_next = len_reg;
        bend_next = bend_reg; ts_next = ts_reg; pos_next = pos_reg;
        fi_next = fi_reg; req_next = req_reg; k_next = k_reg; any_next = any_reg;
        rv_next = rv_reg; res_next = res_reg;
        div_start = 1'b0; div_a = '0; div_b = '0;
        wr_en = 1'b0; wr_s = pos_reg; wr_e = pe;

        if (rv_reg && res_ready)
            rv_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    req_next   = q_req.requester;
                    tries_next = 2'd0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (full_reg == '0 && !fin_reg && tries_reg != 2'd2)
                begin
                    tries_next = tries_reg + 2'd1;
                    if (n_eff == 7'd1 || (DataW+7)'(rem_reg) < thresh)
                    begin
                        len_next   = rem_reg;
                        fin_next   = 1'b1;
                        div_start  = 1'b1;
                        div_a      = rem_reg + DataW'(n_eff) - DataW'(1);
                        div_b      = (NodeW+1)'(n_eff);
                        state_next = S_DIV2;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = rem_reg;
                        div_b      = (NodeW+1)'(n_eff + 7'd1);
                        state_next = S_DIV1;
                    end
                end
                else
                    state_next = S_PICK;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    len_next   = div_q;
                    div_start  = 1'b1;
                    div_a      = div_q + DataW'(n_eff) - DataW'(1);
                    div_b      = (NodeW+1)'(n_eff);
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                // slot size ceil(len/n)
                if (div_done)
                begin
                    ts_next   = div_q;
                    bend_next = nbs_reg + len_reg;
                    pos_next  = nbs_reg;
                    rem_next  = rem_reg - len_reg;
                    nbs_next  = nbs_reg + len_reg;
                    full_next = '0;
                    fi_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (fi_ext < n_eff && pos_reg < bend_reg)
                begin
                    wr_en    = 1'b1;
                    full_next[fi_reg] = 1'b1;
                    pos_next = pe;
                    if (fi_ext == 7'(MAX_NODES - 1))
                        state_next = S_CHECK;
                    else
                        fi_next = fi_reg + SlotW'(1);
                end
                else
                    state_next = S_CHECK;
            end
            S_PICK:
            begin
                any_next = (full_reg != '0);
                k_next   = req_ok ? SlotW'(req_reg) : (found ? lowest : '0);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rv_reg)
                begin
                    rv_next = 1'b1;
                    if (any_reg)
                    begin
                        full_next[k_reg] = 1'b0;
                        res_next.granted    = 1'b1;
                        res_next.task_start = rd_s;
                        res_next.task_end   = rd_e;
                    end
                    else
                    begin
                        res_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_we)
        begin
            rem_next  = (cfg_index == CfgTotalSize) ? cfg_data : total_reg;
            nbs_next  = '0;
            fin_next  = 1'b0;
            full_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ncfg_reg  <= NodeW'(1);
            total_reg <= '0;
            rem_reg   <= '0;
            nbs_reg   <= '0;
            fin_reg   <= 1'b0;
            full_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            nbs_reg   <= nbs_next;
            fin_reg   <= fin_next;
            full_reg  <= full_next;
            rv_reg    <= rv_next;
            if (cfg_we && cfg_index == CfgNodeCount)
                ncfg_reg <= cfg_data[NodeW-1:0];
            if (cfg_we && cfg_index == CfgTotalSize)
                total_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        tries_reg <= tries_next; len_reg <= len_next; bend_reg <= bend_next;
        ts_reg <= ts_next; pos_reg <= pos_next;
        fi_reg <= fi_next; req_reg <= req_next; k_reg <= k_next;
        any_reg <= any_next; res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sstart_mem[fi_reg] <= wr_s;
            send_mem[fi_reg]   <= wr_e;
        end
        rd_s <= sstart_mem[k_next];
        rd_e <= send_mem[k_next];
    end

`ifndef SYNTH
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && !rv_reg && any_reg && !cfg_we |=> !full_reg[$past(k_reg)])
        else $error("slot not cleared");
    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_we) |-> rem_reg <= $past(rem_reg)) else $error("remaining grew");
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> state_reg == S_IDLE) else $error("result pending outside idle");
`endif

endmodule

// ===== sv/affinity_chunk_task_dispatcher.sv =====
// A request goes from the front queue through the check, pick and output states to
// the result register; when no slot is ready, a split bundle first runs two serial
// divisions (bundle length, then slot size) and fills its slots; a final bundle needs
// only the second division. One request at a time: the next request is taken only
// once the result transaction has gone.
// Reset (rst_n, asynchronous): node_count 1, total_size 0, no bundle loaded.
module affinity_chunk_task_dispatcher #(
    parameter int unsigned MAX_NODES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] requester
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // [0] granted, [32:1] task_start, [64:33] task_end
);
    import acd_pkg::*;

    acd_req_t in_req, q_req;
    acd_res_t res;
    logic     q_valid, q_ready;

    assign in_req.requester = s_axis_tdata[ReqW-1:0];

    acd_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    acd_back #(.MAX_NODES(MAX_NODES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {7'd0, res.task_end, res.task_start, res.granted};

endmodule

// ===== tb/sv/tb_affinity_chunk_task_dispatcher.sv =====
// Testbench for the affinity chunk task dispatcher: drives requests over the stream
// port, predicts each grant in-house and checks every result transaction.
// Depends on acd_pkg and affinity_chunk_task_dispatcher.
module tb_affinity_chunk_task_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;
    import acd_pkg::*;

    localparam int MaxNodes = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [3:0] requester
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // [0] granted, [32:1] task_start, [64:33] task_end

    affinity_chunk_task_dispatcher #(.MAX_NODES(MaxNodes)) dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // dispatcher state as predicted
    logic [4:0]  nodes_reg;
    logic [31:0] total_reg;
    logic [31:0] unbundled;
    logic [31:0] bundle_next;
    logic        last_bundle;
    logic [15:0] full_mask;
    logic [31:0] range_lo [MaxNodes];
    logic [31:0] range_hi [MaxNodes];

    logic [3:0]  request_queue [$];
    acd_res_t    grant_queue [$];
    int          errors = 0;
    bit          calm = 1'b0;
    bit          feeding = 1'b0;

    function automatic int active_nodes();
        if (nodes_reg == 0)
            return 1;
        if (nodes_reg > MaxNodes)
            return MaxNodes;
        return int'(nodes_reg);
    endfunction

    function automatic void restart_dispatch();
        unbundled = total_reg;
        bundle_next = '0;
        last_bundle = 1'b0;
        full_mask = '0;
    endfunction

    function automatic void cut_bundle();
        int unsigned n;
        logic [32:0] len, slot_len, pos, stop, e;
        n = active_nodes();
        if (n == 1 || 64'(unbundled) < 64'(SplitThreshold) * n)
        begin
            len = unbundled;
            last_bundle = 1'b1;
        end
        else
            len = unbundled / (n + 1);
        pos = bundle_next;
        e = pos + len;
        unbundled = unbundled - len[31:0];
        bundle_next = e[31:0];
        full_mask = '0;
        slot_len = (len + n - 1) / n;
        for (int i = 0; i < n && pos < e; i++)
        begin
            stop = pos + slot_len;
            if (stop > e)
                stop = e;
            range_lo[i] = pos[31:0];
            range_hi[i] = stop[31:0];
            full_mask[i] = 1'b1;
            pos = stop;
        end
    endfunction

    function automatic acd_res_t predict_grant(logic [3:0] req);
        acd_res_t r;
        int n, k;
        n = active_nodes();
        r = '0;
        for (int t = 0; t < 2 && full_mask == 0 && !last_bundle; t++)
            cut_bundle();
        if (full_mask == 0)
            return r;
        if (req < n && full_mask[req])
            k = req;
        else
        begin
            k = 0;
            while (k < n && !full_mask[k])
                k++;
        end
        if (k >= MaxNodes)
            k = 0;
        full_mask[k] = 1'b0;
        r.granted = 1'b1;
        r.task_start = range_lo[k];
        r.task_end = range_hi[k];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: predict at acceptance so config writes stay in order
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            grant_queue.push_back(predict_grant(s_axis_tdata[3:0]));
            void'(request_queue.pop_front());
        end
        if ((s_axis_tvalid && !s_axis_tready) ||
            (feeding && request_queue.size() > 0
             && (calm || $urandom_range(99) >= 32)))
        begin
            s_axis_tvalid <= 1'b1;
            if (!(s_axis_tvalid && !s_axis_tready))
                s_axis_tdata <= {4'b0, request_queue[0]};
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        acd_res_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.granted    = m_axis_tdata[0];
            got.task_start = m_axis_tdata[32:1];
            got.task_end   = m_axis_tdata[64:33];
            if (grant_queue.size() == 0)
            begin
                $display("unexpected result transaction at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = grant_queue.pop_front();
                if (got.granted !== want.granted)
                    report_mismatch("granted", 32'(got.granted), 32'(want.granted));
                if (got.task_start !== want.task_start)
                    report_mismatch("task_start", got.task_start, want.task_start);
                if (got.task_end !== want.task_end)
                    report_mismatch("task_end", got.task_end, want.task_end);
            end
        end
        m_axis_tready <= calm || $urandom_range(99) >= 32;
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgNodeCount)
            nodes_reg = value[4:0];
        else
            total_reg = value;
        restart_dispatch();
    endtask

    task automatic run_phase(logic [4:0] nodes, logic [31:0] total, int count);
        write_reg(CfgNodeCount, {27'b0, nodes});
        write_reg(CfgTotalSize, total);
        for (int i = 0; i < count; i++)
            request_queue.push_back(4'($urandom));
        feeding = 1'b1;
        while (request_queue.size() != 0 || s_axis_tvalid || grant_queue.size() != 0)
            @(posedge clk);
        feeding = 1'b0;
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int issued;
        nodes_reg = 5'd1;
        total_reg = '0;
        restart_dispatch();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        // directed: empty problem, single node, extremes of both registers
        run_phase(5'd1, 32'd0, 2);
        run_phase(5'd0, 32'd37, 2);
        run_phase(5'd16, 32'hFFFF_FFFF, 5);
        run_phase(5'd31, 32'd1000, 3);
        write_reg(CfgTotalSize, 32'd5);
        run_phase(5'd4, 32'd1599, 10);
        issued = 0;
        calm = 1'b0;
        while (issued < 800)
        begin
            logic [4:0] n;
            logic [31:0] t;
            int cnt;
            n = 5'($urandom_range(17, 0));
            case ($urandom_range(3))
                0: t = $urandom_range(20);
                1: t = $urandom_range(3000);
                2: t = $urandom_range(200000);
                default: t = $urandom;
            endcase
            cnt = $urandom_range(40, 5);
            calm = (issued > 300 && issued < 400);
            run_phase(n, t, cnt);
            issued += cnt;
        end
        calm = 1'b0;
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
